FILE: sv/itj_pkg.sv
// Package for the id-list temporal join core: sizes, entry and token types,
// opcodes, join kinds and controller states. Depends on nothing.
`default_nettype none
package itj_pkg;

  localparam int LIST_DEPTH   = 32;
  localparam int SEQ_ID_BITS  = 16;
  localparam int TIME_ID_BITS = 16;

  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int CYC_W  = $clog2(2 * LIST_DEPTH + 1);
  localparam int ID_W   = 16;
  localparam int SUP_W  = 6;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;

  typedef logic [SEQ_ID_BITS-1:0]  seq_t;
  typedef logic [TIME_ID_BITS-1:0] tid_t;

  typedef struct packed {
    seq_t seq;
    tid_t tm;
  } entry_t;

  // probe token moving down the cell row
  typedef struct packed {
    logic   valid;
    logic   found;
    entry_t entry;
  } token_t;

  // shared by all cells during a run
  typedef struct packed {
    logic inner_is_a;
    logic rel_gt;
  } cell_ctrl_t;

  // per-cell write strobes and inner occupancy
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic inner_valid;
  } cell_sel_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND_A = 2'd1,
    OP_APPEND_B = 2'd2,
    OP_RUN      = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAME_A    = 2'd0,
    KIND_B_AFTER_A = 2'd1,
    KIND_A_AFTER_B = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: sv/itj_cell.sv
// One cell of the join row: holds entry k of list A and list B and matches
// the passing probe token against the inner one. Depends on itj_pkg.
`default_nettype none
module itj_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  itj_pkg::cell_sel_t  sel,
  input  itj_pkg::cell_ctrl_t ctrl,
  input  itj_pkg::entry_t     wr_entry,
  input  itj_pkg::token_t     tok_in,
  output itj_pkg::token_t     tok_out,
  output itj_pkg::entry_t     a_entry,
  output itj_pkg::entry_t     b_entry
);

  itj_pkg::entry_t a_r, b_r, inner;
  itj_pkg::entry_t ent_r, ent_nxt;
  logic            valid_r, valid_nxt;
  logic            found_r, found_nxt;
  logic            time_ok, hit;

  assign inner   = ctrl.inner_is_a ? a_r : b_r;
  assign time_ok = ctrl.rel_gt ? (tok_in.entry.tm > inner.tm) : (tok_in.entry.tm == inner.tm);
  assign hit     = sel.inner_valid && (tok_in.entry.seq == inner.seq) && time_ok;

  assign valid_nxt = tok_in.valid;
  assign found_nxt = tok_in.found | hit;
  assign ent_nxt   = tok_in.entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    ent_r   <= ent_nxt;
    if (sel.wr_a) begin
      a_r <= wr_entry;
    end
    if (sel.wr_b) begin
      b_r <= wr_entry;
    end
  end

  assign tok_out = '{valid: valid_r, found: found_r, entry: ent_r};
  assign a_entry = a_r;
  assign b_entry = b_r;

endmodule
`default_nettype wire

FILE: sv/idlist_temporal_join_core.sv
// Id-list temporal join: appends and clears are taken while idle; a run first
// passes the outer list through the cell row, then emits its results in order.
// Throughput: one append or clear per cycle; in_ready stays low from a run
// transfer until its summary sits in the output register (kept + 1 results
// when frequent, the summary alone otherwise).
// Reset (rst_n low, synchronous): lists empty, overflow clear, min_support 1.
`default_nettype none
module idlist_temporal_join_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itj_pkg::OP_W-1:0]      in_opcode,
  input  logic [itj_pkg::ID_W-1:0]      in_seq_id,
  input  logic [itj_pkg::ID_W-1:0]      in_time_id,
  input  logic [itj_pkg::KIND_W-1:0]    in_join_kind,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itj_pkg::ID_W-1:0]      out_seq_id,
  output logic [itj_pkg::ID_W-1:0]      out_time_id,
  output logic [itj_pkg::SUP_W-1:0]     out_support,
  output logic                          out_frequent,
  output logic                          out_overflow,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [itj_pkg::SUP_W-1:0]     cfg_wr_data
);

  localparam int D = itj_pkg::LIST_DEPTH;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  itj_pkg::state_t             state_r, state_nxt;
  itj_pkg::kind_t              kind_r;
  logic [itj_pkg::CNT_W-1:0]   cnt_a_r, cnt_b_r;
  logic                        ovf_r;
  logic [itj_pkg::SUP_W-1:0]   min_sup_r;
  logic [itj_pkg::CYC_W-1:0]   cyc_r;    // probe cycle counter
  logic [itj_pkg::CNT_W-1:0]   kept_r;   // entries written to the joined store
  logic [itj_pkg::CNT_W-1:0]   sup_r;    // seq id changes along kept entries
  logic [itj_pkg::CNT_W-1:0]   em_r;     // emit pointer
  itj_pkg::seq_t               prev_seq_r;
  itj_pkg::entry_t             joined_r [D];

  // output register
  logic                        out_valid_r;
  itj_pkg::entry_t             out_ent_r, out_ent_nxt;
  logic [itj_pkg::SUP_W-1:0]   out_sup_r, out_sup_nxt;
  logic                        out_freq_r, out_freq_nxt;
  logic                        out_ovf_r;
  logic                        out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  itj_pkg::op_t    op;
  logic            in_xfer;
  logic            do_clear, do_app_a, do_app_b, do_run;
  itj_pkg::entry_t wr_entry;

  assign op       = itj_pkg::op_t'(in_opcode);
  assign in_xfer  = in_valid && in_ready;
  assign do_clear = in_xfer && (op == itj_pkg::OP_CLEAR);
  assign do_app_a = in_xfer && (op == itj_pkg::OP_APPEND_A);
  assign do_app_b = in_xfer && (op == itj_pkg::OP_APPEND_B);
  assign do_run   = in_xfer && (op == itj_pkg::OP_RUN);
  assign wr_entry = '{seq: itj_pkg::seq_t'(in_seq_id), tm: itj_pkg::tid_t'(in_time_id)};

  // ---------------------------------------------------------------------
  // Join kind decode: which list is outer, which relation applies
  // ---------------------------------------------------------------------
  itj_pkg::cell_ctrl_t       ctrl;
  logic [itj_pkg::CNT_W-1:0] n_outer, n_inner;

  always_comb begin
    ctrl    = '{inner_is_a: 1'b0, rel_gt: 1'b0};
    n_outer = '0;
    n_inner = '0;
    case (kind_r)
      itj_pkg::KIND_SAME_A: begin
        n_outer = cnt_a_r;
        n_inner = cnt_b_r;
      end
      itj_pkg::KIND_B_AFTER_A: begin
        ctrl    = '{inner_is_a: 1'b1, rel_gt: 1'b1};
        n_outer = cnt_b_r;
        n_inner = cnt_a_r;
      end
      itj_pkg::KIND_A_AFTER_B: begin
        ctrl.rel_gt = 1'b1;
        n_outer     = cnt_a_r;
        n_inner     = cnt_b_r;
      end
      default: begin
        // nothing joins; only the summary comes out
        n_outer = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Cell row. Cell k stores entry k of both lists; tokens carry outer
  // entries down the row, one cell per cycle, and pick up a found flag.
  // ---------------------------------------------------------------------
  itj_pkg::entry_t a_ent [D];
  itj_pkg::entry_t b_ent [D];
  itj_pkg::token_t tok   [D];
  itj_pkg::token_t inj_tok;
  logic            inj_valid;
  logic [itj_pkg::IDX_W-1:0] inj_idx;

  assign inj_idx = cyc_r[itj_pkg::IDX_W-1:0];
  assign inj_tok = '{valid: inj_valid, found: 1'b0,
                     entry: ctrl.inner_is_a ? b_ent[inj_idx] : a_ent[inj_idx]};

  for (genvar k = 0; k < D; k++) begin : g_cell
    itj_pkg::cell_sel_t sel;
    assign sel.wr_a        = do_app_a && (cnt_a_r == itj_pkg::CNT_W'(k));
    assign sel.wr_b        = do_app_b && (cnt_b_r == itj_pkg::CNT_W'(k));
    assign sel.inner_valid = itj_pkg::CNT_W'(k) < n_inner;

    itj_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .sel      (sel),
      .ctrl     (ctrl),
      .wr_entry (wr_entry),
      .tok_in   ((k == 0) ? inj_tok : tok[(k == 0) ? 0 : k - 1]),
      .tok_out  (tok[k]),
      .a_entry  (a_ent[k]),
      .b_entry  (b_ent[k])
    );
  end

  // ---------------------------------------------------------------------
  // Collector at the row's end: keeps found tokens in order and counts
  // seq id changes as they arrive.
  // ---------------------------------------------------------------------
  itj_pkg::token_t col;
  logic            col_keep, col_new_seq;
  logic            probe_last;

  assign col         = tok[D-1];
  assign col_keep    = (state_r == itj_pkg::ST_PROBE) && col.valid && col.found;
  assign col_new_seq = (kept_r == '0) || (col.entry.seq != prev_seq_r);
  // probe_last marks the cycle in which the last outer token sits at the row's end
  assign probe_last  = cyc_r == (itj_pkg::CYC_W'(n_outer) + itj_pkg::CYC_W'(D - 1));

  // ---------------------------------------------------------------------
  // Emit decisions
  // ---------------------------------------------------------------------
  logic out_load, freq, emit_entry;

  assign out_load   = !out_valid_r || out_ready;
  assign freq       = itj_pkg::SUP_W'(sup_r) >= min_sup_r;
  assign emit_entry = freq && (em_r < kept_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itj_pkg::ST_IDLE: begin
        if (do_run) begin
          state_nxt = itj_pkg::ST_PROBE;
        end
      end
      itj_pkg::ST_PROBE: begin
        if (probe_last) begin
          state_nxt = itj_pkg::ST_EMIT;
        end
      end
      itj_pkg::ST_EMIT: begin
        if (out_load && !emit_entry) begin
          state_nxt = itj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itj_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready     = 1'b0;
    inj_valid    = 1'b0;
    out_ent_nxt  = '0;
    out_sup_nxt  = '0;
    out_freq_nxt = 1'b0;
    out_last_nxt = 1'b0;
    case (state_r)
      itj_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      itj_pkg::ST_PROBE: begin
        inj_valid = cyc_r < itj_pkg::CYC_W'(n_outer);
      end
      itj_pkg::ST_EMIT: begin
        if (emit_entry) begin
          out_ent_nxt = joined_r[em_r[itj_pkg::IDX_W-1:0]];
        end else begin
          out_sup_nxt  = itj_pkg::SUP_W'(sup_r);
          out_freq_nxt = freq;
          out_last_nxt = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itj_pkg::ST_IDLE;
      kind_r      <= itj_pkg::KIND_SAME_A;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      min_sup_r   <= itj_pkg::SUP_W'(1);
      cyc_r       <= '0;
      kept_r      <= '0;
      sup_r       <= '0;
      em_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        min_sup_r <= cfg_wr_data;
      end
      if (do_clear) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (do_app_a) begin
        if (cnt_a_r == itj_pkg::CNT_W'(D)) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_a_r <= cnt_a_r + 1'b1;
        end
      end
      if (do_app_b) begin
        if (cnt_b_r == itj_pkg::CNT_W'(D)) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_b_r <= cnt_b_r + 1'b1;
        end
      end
      if (do_run) begin
        kind_r <= itj_pkg::kind_t'(in_join_kind);
        cyc_r  <= '0;
        kept_r <= '0;
        sup_r  <= '0;
        em_r   <= '0;
      end
      if (state_r == itj_pkg::ST_PROBE) begin
        cyc_r <= cyc_r + 1'b1;
      end
      if (col_keep) begin
        kept_r <= kept_r + 1'b1;
        if (col_new_seq) begin
          sup_r <= sup_r + 1'b1;
        end
      end
      if (state_r == itj_pkg::ST_EMIT && out_load) begin
        out_valid_r <= 1'b1;
        if (emit_entry) begin
          em_r <= em_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: joined store and output register
  always_ff @(posedge clk) begin
    if (col_keep) begin
      joined_r[kept_r[itj_pkg::IDX_W-1:0]] <= col.entry;
      prev_seq_r                           <= col.entry.seq;
    end
    if (state_r == itj_pkg::ST_EMIT && out_load) begin
      out_ent_r  <= out_ent_nxt;
      out_sup_r  <= out_sup_nxt;
      out_freq_r <= out_freq_nxt;
      out_ovf_r  <= ovf_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_seq_id   = itj_pkg::ID_W'(out_ent_r.seq);
  assign out_time_id  = itj_pkg::ID_W'(out_ent_r.tm);
  assign out_support  = out_sup_r;
  assign out_frequent = out_freq_r;
  assign out_overflow = out_ovf_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

FILE: sv/itj_checker.sv
// Port-level checks for idlist_temporal_join_core, bound to the top level.
// Depends on itj_pkg.
`default_nettype none
module itj_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [itj_pkg::OP_W-1:0]   in_opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [itj_pkg::ID_W-1:0]   out_seq_id,
  input logic [itj_pkg::ID_W-1:0]   out_time_id,
  input logic [itj_pkg::SUP_W-1:0]  out_support,
  input logic                       out_frequent,
  input logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seq_id) && $stable(out_last))
    else $error("result changed while stalled");

  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_support == '0 && !out_frequent)
    else $error("kept entry carries summary fields");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_seq_id == '0 && out_time_id == '0)
    else $error("summary carries entry fields");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == itj_pkg::OP_RUN |=> !in_ready)
    else $error("input taken during a run");

endmodule

bind idlist_temporal_join_core itj_checker u_itj_checker (.*);
`default_nettype wire

FILE: tb/itj_join_checker.sv
`timescale 1ns / 100ps
// Join checker for idlist_temporal_join_core: follows list contents and min_support,
// predicts the rows of every run and compares each output transfer in order.
// Depends on itj_pkg.
module itj_join_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [itj_pkg::OP_W-1:0]  in_opcode,
  input  logic [itj_pkg::ID_W-1:0]  in_seq_id,
  input  logic [itj_pkg::ID_W-1:0]  in_time_id,
  input  logic [itj_pkg::KIND_W-1:0] in_join_kind,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [itj_pkg::ID_W-1:0]  out_seq_id,
  input  logic [itj_pkg::ID_W-1:0]  out_time_id,
  input  logic [itj_pkg::SUP_W-1:0] out_support,
  input  logic                      out_frequent,
  input  logic                      out_overflow,
  input  logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [itj_pkg::SUP_W-1:0] cfg_wr_data,
  output int                        mismatches,
  output int                        rows_owed
);
  import itj_pkg::*;

  // at most two runs' rows are ever owed at once
  localparam int ROW_DEPTH = 128;

  typedef struct packed {
    logic [ID_W-1:0]  seq;
    logic [ID_W-1:0]  tm;
    logic [SUP_W-1:0] support;
    logic             frequent;
    logic             overflow;
    logic             last;
  } join_row_t;

  entry_t           list_a [LIST_DEPTH];
  entry_t           list_b [LIST_DEPTH];
  int unsigned      a_cnt;
  int unsigned      b_cnt;
  logic             ovf_seen;
  logic [SUP_W-1:0] min_sup;
  join_row_t        join_rows [ROW_DEPTH];
  int               row_wr = 0;
  int               row_rd = 0;

  task automatic flag_mismatch(input string what, input join_row_t got, input join_row_t want);
    mismatches++;
    $display({"%0t ns join row %s: got seq %h tm %h sup %0d frq %b ovf %b last %b,",
              " want seq %h tm %h sup %0d frq %b ovf %b last %b"},
             $time, what, got.seq, got.tm, got.support, got.frequent, got.overflow, got.last,
             want.seq, want.tm, want.support, want.frequent, want.overflow, want.last);
  endtask

  task automatic add_row(input join_row_t row);
    join_rows[row_wr % ROW_DEPTH] = row;
    row_wr++;
  endtask

  task automatic add_entry(input logic to_a, input entry_t e);
    if (to_a) begin
      if (a_cnt >= LIST_DEPTH) ovf_seen = 1'b1;
      else begin
        list_a[a_cnt] = e;
        a_cnt++;
      end
    end else begin
      if (b_cnt >= LIST_DEPTH) ovf_seen = 1'b1;
      else begin
        list_b[b_cnt] = e;
        b_cnt++;
      end
    end
  endtask

  // walk outer list, keep each outer entry with a matching inner entry
  task automatic predict_join_run(input kind_t kind);
    entry_t      kept_buf [LIST_DEPTH];
    int          n_kept;
    entry_t      o;
    entry_t      c;
    int unsigned n_outer;
    int unsigned n_inner;
    int unsigned sup;
    logic        outer_a;
    logic        rel_gt;
    logic        freq;
    join_row_t   row;
    sup = 0;
    n_kept = 0;
    if (kind != KIND_EMPTY) begin
      outer_a = (kind != KIND_B_AFTER_A);
      rel_gt  = (kind != KIND_SAME_A);
      n_outer = outer_a ? a_cnt : b_cnt;
      n_inner = outer_a ? b_cnt : a_cnt;
      for (int i = 0; i < n_outer; i++) begin
        o = outer_a ? list_a[i] : list_b[i];
        for (int j = 0; j < n_inner; j++) begin
          c = outer_a ? list_b[j] : list_a[j];
          if (o.seq == c.seq && (rel_gt ? (o.tm > c.tm) : (o.tm == c.tm))) begin
            kept_buf[n_kept] = o;
            n_kept++;
            break;
          end
        end
      end
    end
    // support counts seq id changes along the kept list
    for (int i = 0; i < n_kept; i++)
      if (i == 0 || kept_buf[i].seq != kept_buf[i-1].seq) sup++;
    freq = (sup >= min_sup);
    if (freq)
      for (int i = 0; i < n_kept; i++) begin
        row = '0;
        row.seq = kept_buf[i].seq;
        row.tm = kept_buf[i].tm;
        row.overflow = ovf_seen;
        add_row(row);
      end
    row = '0;
    row.support = SUP_W'(sup);
    row.frequent = freq;
    row.overflow = ovf_seen;
    row.last = 1'b1;
    add_row(row);
  endtask

  always @(posedge clk) begin : watch
    join_row_t got;
    join_row_t want;
    entry_t    e;
    string     bad;
    if (!rst_n) begin
      a_cnt = 0;
      b_cnt = 0;
      ovf_seen = 1'b0;
      min_sup = SUP_W'(1);
      row_wr = 0;
      row_rd = 0;
    end else begin
      if (cfg_wr_en) min_sup = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = '{out_seq_id, out_time_id, out_support, out_frequent, out_overflow, out_last};
        if (row_wr == row_rd) flag_mismatch("with nothing owed", got, '0);
        else begin
          want = join_rows[row_rd % ROW_DEPTH];
          row_rd++;
          bad = "";
          if (got.seq !== want.seq) bad = {bad, " seq"};
          if (got.tm !== want.tm) bad = {bad, " time"};
          if (got.support !== want.support) bad = {bad, " support"};
          if (got.frequent !== want.frequent) bad = {bad, " frequent"};
          if (got.overflow !== want.overflow) bad = {bad, " overflow"};
          if (got.last !== want.last) bad = {bad, " last"};
          if (bad != "") flag_mismatch({"differs in", bad}, got, want);
        end
      end
      if (in_valid && in_ready) begin
        e.seq = in_seq_id;
        e.tm = in_time_id;
        case (op_t'(in_opcode))
          OP_CLEAR: begin
            a_cnt = 0;
            b_cnt = 0;
            ovf_seen = 1'b0;
          end
          OP_APPEND_A: add_entry(1'b1, e);
          OP_APPEND_B: add_entry(1'b0, e);
          OP_RUN: predict_join_run(kind_t'(in_join_kind));
          default: ;
        endcase
      end
    end
    rows_owed <= row_wr - row_rd;
  end

endmodule

FILE: tb/idlist_temporal_join_core_test.sv
`timescale 1ns / 100ps
// Top of the id-list temporal join testbench: drives clears, appends, runs and
// min_support writes into idlist_temporal_join_core, with itj_join_checker beside it.
// Depends on itj_pkg, itj_join_checker and the core.
module idlist_temporal_join_core_test;
  import itj_pkg::*;

  // worst run: a full probe pass plus 33 rows, each possibly stalled by backpressure;
  // a few hundred runs stay far below this
  localparam int LIMIT  = 400000;
  // quiet cycles after the last row: covers a run's full probe pass
  localparam int TAIL   = 2 * LIST_DEPTH + 16;
  localparam int SETTLE = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode = OP_CLEAR;
  logic [ID_W-1:0]   in_seq_id = '0;
  logic [ID_W-1:0]   in_time_id = '0;
  logic [KIND_W-1:0] in_join_kind = KIND_SAME_A;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [ID_W-1:0]   out_seq_id;
  logic [ID_W-1:0]   out_time_id;
  logic [SUP_W-1:0]  out_support;
  logic              out_frequent;
  logic              out_overflow;
  logic              out_last;
  logic              cfg_wr_en = 1'b0;
  logic [SUP_W-1:0]  cfg_wr_data = '0;

  int   cycles = 0;
  int   mismatches;
  int   rows_owed;
  int   items_sent = 0;
  int   rx_hold = 0;
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;

  always #1 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  idlist_temporal_join_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_seq_id    (in_seq_id),
    .in_time_id   (in_time_id),
    .in_join_kind (in_join_kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_seq_id   (out_seq_id),
    .out_time_id  (out_time_id),
    .out_support  (out_support),
    .out_frequent (out_frequent),
    .out_overflow (out_overflow),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  itj_join_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_seq_id    (in_seq_id),
    .in_time_id   (in_time_id),
    .in_join_kind (in_join_kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_seq_id   (out_seq_id),
    .out_time_id  (out_time_id),
    .out_support  (out_support),
    .out_frequent (out_frequent),
    .out_overflow (out_overflow),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .rows_owed    (rows_owed)
  );

  // Result side backpressure: bursts with ready low, started at random while rx
  // idling is on; ready held high otherwise.
  always @(posedge clk) begin
    if (!rx_idle_on) begin
      out_ready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [ID_W-1:0] rnd16();
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic kind_t rnd_kind();
    return kind_t'($urandom_range(0, 3));
  endfunction

  // One input transfer. An optional gap drops valid first; otherwise valid
  // stays high from the previous transfer and only the payload moves.
  task automatic send(input op_t op, input logic [ID_W-1:0] s, input logic [ID_W-1:0] t,
                      input kind_t k);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seq_id <= s;
    in_time_id <= t;
    in_join_kind <= k;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic append(input logic to_a, input logic [ID_W-1:0] s, input logic [ID_W-1:0] t);
    send(to_a ? OP_APPEND_A : OP_APPEND_B, s, t, rnd_kind());
  endtask

  task automatic run_join(input kind_t k);
    send(OP_RUN, rnd16(), rnd16(), k);
  endtask

  task automatic clear_lists();
    send(OP_CLEAR, rnd16(), rnd16(), rnd_kind());
  endtask

  // Sender holds off until every predicted row is out, then lets the core settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_owed != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_min_support(input logic [SUP_W-1:0] v);
    drain(SETTLE);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Well-formed batch: A and B grouped by seq id over a shared small id pool,
  // small time ids so equal/after relations hit often, then a few runs.
  // Sometimes the clear is skipped so lists pile up toward overflow.
  task automatic grouped_batch();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] s;
    int              groups;
    int              n;
    int              runs;
    base = rnd16();
    if ($urandom_range(0, 3) != 0) clear_lists();
    for (int side = 0; side < 2; side++) begin
      groups = $urandom_range(1, 4);
      for (int g = $urandom_range(0, 1); g < groups; g++) begin
        s = base + ID_W'(g);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          append(side == 0, s, ID_W'($urandom_range(0, 6)));
      end
    end
    runs = $urandom_range(1, 3);
    for (int r = 0; r < runs; r++)
      run_join($urandom_range(0, 7) == 0 ? KIND_EMPTY : kind_t'($urandom_range(0, 2)));
    if ($urandom_range(0, 3) == 0) drain(0);
  endtask

  // Noise: any opcode, full-range fields, any join kind.
  task automatic noise_batch();
    int n;
    n = $urandom_range(2, 6);
    repeat (n) send(op_t'($urandom_range(0, 3)), rnd16(), rnd16(), rnd_kind());
  endtask

  // Both lists filled with 32 distinct seq ids in matching pairs, plus drops
  // past capacity: the KIND_SAME_A run gives support 32 with overflow set.
  task automatic fill_batch();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] t;
    base = rnd16();
    clear_lists();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      t = ID_W'($urandom_range(0, 3));
      append(1'b1, base + ID_W'(i), t);
      append(1'b0, base + ID_W'(i), t);
    end
    append(1'b1, rnd16(), rnd16());
    append(1'b0, rnd16(), rnd16());
    run_join(KIND_SAME_A);
    run_join(kind_t'($urandom_range(1, 3)));
  endtask

  function automatic logic [SUP_W-1:0] phase_min_support(input int ph);
    case (ph)
      0: return SUP_W'(2);
      1: return SUP_W'(32);
      2: return '0;
      3: return SUP_W'(1);
      4: return SUP_W'($urandom_range(3, 6));
      default: return SUP_W'($urandom_range(1, 2));
    endcase
  endfunction

  initial begin : stimulus
    int budget;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: min_support at reset value 1 ---
    run_join(KIND_SAME_A);                 // empty lists: summary only
    append(1'b1, 16'h0000, 16'h0000);
    append(1'b1, 16'h0000, 16'h0005);
    append(1'b1, 16'hFFFF, 16'hFFFF);
    append(1'b1, 16'hFFFF, 16'h0001);
    append(1'b0, 16'h0000, 16'h0005);
    append(1'b0, 16'h0000, 16'h0000);
    append(1'b0, 16'hFFFF, 16'h0000);
    append(1'b0, 16'hFFFF, 16'hFFFF);
    run_join(KIND_SAME_A);
    run_join(KIND_B_AFTER_A);
    run_join(KIND_A_AFTER_B);
    run_join(KIND_EMPTY);                  // nothing kept, support zero
    set_min_support('0);                   // every run frequent, empty ones too
    run_join(KIND_EMPTY);
    run_join(KIND_SAME_A);
    set_min_support(SUP_W'(32));
    run_join(KIND_A_AFTER_B);
    clear_lists();
    run_join(KIND_B_AFTER_A);
    set_min_support('0);
    run_join(KIND_SAME_A);

    // --- random phases; last one runs without any idling ---
    for (int ph = 0; ph < 6; ph++) begin
      set_min_support(phase_min_support(ph));
      tx_idle_on <= (ph != 5 && ph != 2);
      rx_idle_on <= (ph != 5 && ph != 1);
      if (ph == 1) fill_batch();
      budget = items_sent + 22;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) < 7) grouped_batch();
        else noise_batch();
      end
    end

    drain(TAIL);
    if (mismatches == 0 && rows_owed == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    while (cycles < LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: idlist_temporal_join_core.f
sv/itj_pkg.sv
sv/itj_cell.sv
sv/idlist_temporal_join_core.sv
sv/itj_checker.sv
tb/itj_join_checker.sv
tb/idlist_temporal_join_core_test.sv
